// ----- design/osm_pkg.sv -----
// shared types, codes and defaults for the order statistic multiset
`default_nettype none
package osm_pkg;

	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_COUNT_BITS = 16;
	localparam int KEY_W          = 32;
	localparam int RANK_W         = 22;
	localparam int CNT_OUT_W      = 16;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_COUNT  = 2'd2;
	localparam logic [1:0] OP_SELECT = 2'd3;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]              opcode;
		logic signed [KEY_W-1:0] key;
		logic [RANK_W-1:0]       rank;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [CNT_OUT_W-1:0]    count;
		logic signed [KEY_W-1:0] value;
	} rsp_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INC,
		CELL_DEC,
		CELL_INS,
		CELL_DEL
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     cmp_en;
		logic     adv;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY,
		S_WALK
	} state_t;

endpackage
`default_nettype wire

// ----- design/osm_cell.sv -----
// one slot of the sorted chain: key, multiplicity, compare flags and rank token stage
`default_nettype none
module osm_cell import osm_pkg::*; #(
	parameter int COUNT_BITS = DEF_COUNT_BITS,
	parameter int SUM_W      = RANK_W
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cell_ctl_t               ctl,
	input  wire logic signed [KEY_W-1:0] key_b,
	input  wire logic                    left_lt,
	input  wire logic signed [KEY_W-1:0] left_key,
	input  wire logic [COUNT_BITS-1:0]   left_cnt,
	input  wire logic signed [KEY_W-1:0] right_key,
	input  wire logic [COUNT_BITS-1:0]   right_cnt,
	input  wire logic                    tok_in,
	input  wire logic [SUM_W-1:0]        res_in,
	output logic signed [KEY_W-1:0]      key,
	output logic [COUNT_BITS-1:0]        cnt,
	output logic                         lt,
	output logic                         eq,
	output logic                         found,
	output logic                         tok_out,
	output logic [SUM_W-1:0]             res_out
);

	logic signed [KEY_W-1:0] key_q;
	logic [COUNT_BITS-1:0]   cnt_q;
	logic                    lt_q, eq_q;
	logic                    tok_q;
	logic [SUM_W-1:0]        res_q;
	logic                    occ;
	logic [SUM_W-1:0]        cnt_ext;

	assign occ     = (cnt_q != '0);
	assign cnt_ext = SUM_W'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			lt_q <= occ && (key_q < key_b);
			eq_q <= occ && (key_q == key_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (ctl.op)
				CELL_INC: begin
					if (eq_q) cnt_q <= cnt_q + 1'b1;
				end
				CELL_DEC: begin
					if (eq_q) cnt_q <= cnt_q - 1'b1;
				end
				CELL_INS: begin
					// the first slot not below the new key takes it, the rest move up
					if (!lt_q) cnt_q <= left_lt ? COUNT_BITS'(1) : left_cnt;
				end
				CELL_DEL: begin
					if (!lt_q) cnt_q <= right_cnt;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INS: begin
				if (!lt_q) key_q <= left_lt ? key_b : left_key;
			end
			CELL_DEL: begin
				if (!lt_q) key_q <= right_key;
			end
			default: begin
			end
		endcase
	end

	// rank token walks one slot per cycle carrying the remaining rank, and holds while ctl.adv is low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.adv) begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) res_q <= res_in;
	end

	assign found   = tok_q && (res_q < cnt_ext);
	assign tok_out = tok_q && !(res_q < cnt_ext);
	assign res_out = res_q - cnt_ext;
	assign key     = key_q;
	assign cnt     = cnt_q;
	assign lt      = lt_q;
	assign eq      = eq_q;

endmodule
`default_nettype wire

// ----- design/order_statistic_multiset.sv -----
// Ordered multiset of signed keys with multiplicities, held sorted in a row of slot cells.
// Insert, remove and count pass through idle, which latches the transaction, S_CMP, where every
// cell compares its key, and S_APPLY, where insert and remove shift the cells or count them up
// or down at once and the result is written. A select whose rank is below the total then walks:
// a rank token moves one cell per cycle, subtracting each multiplicity. Both wait while the
// output register is full. One transaction is in the block at a time; a finished result sits
// in an output register and the block returns to idle once it is written there.
`default_nettype none
module order_statistic_multiset import osm_pkg::*; #(
	parameter int DISTINCT_CAPACITY = DEF_CAPACITY,
	parameter int COUNT_BITS        = DEF_COUNT_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int N       = DISTINCT_CAPACITY;
	localparam int TOTAL_W = COUNT_BITS + $clog2(N);
	localparam int SUM_W   = (RANK_W > COUNT_BITS) ? RANK_W : COUNT_BITS;
	localparam int CMPW    = (RANK_W > TOTAL_W) ? RANK_W : TOTAL_W;

	state_t state_q, state_d;

	logic [1:0]              op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [RANK_W-1:0]       rank_q;
	logic [TOTAL_W-1:0]      total_q;
	rsp_t                    rsp_q, rsp_d;
	logic                    rsp_valid_q;

	cell_ctl_t ctl;
	logic      res_wr, total_inc, total_dec, walk_start, out_free;

	logic signed [KEY_W-1:0] key_a [N];
	logic [COUNT_BITS-1:0]   cnt_a [N];
	logic                    lt_a  [N];
	logic [N-1:0]            eq_vec, occ_vec, found_vec;
	logic                    tok_a [N+1];
	logic [SUM_W-1:0]        res_a [N+1];

	logic                    hit, full, rank_miss, found_any;
	logic [COUNT_BITS-1:0]   hit_cnt;
	logic [COUNT_BITS+CNT_OUT_W-1:0] hit_cnt_ext;
	logic signed [KEY_W-1:0] found_key;

	assign out_free = !rsp_valid_q || rsp_ready;

	assign tok_a[0] = walk_start;
	assign res_a[0] = SUM_W'(rank_q);

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic                    l_lt;
		logic signed [KEY_W-1:0] l_key, r_key;
		logic [COUNT_BITS-1:0]   l_cnt, r_cnt;

		if (i == 0) begin : g_first
			assign l_lt  = 1'b1;
			assign l_key = '0;
			assign l_cnt = '0;
		end else begin : g_mid
			assign l_lt  = lt_a[i-1];
			assign l_key = key_a[i-1];
			assign l_cnt = cnt_a[i-1];
		end

		if (i == N-1) begin : g_last
			assign r_key = '0;
			assign r_cnt = '0;
		end else begin : g_inner
			assign r_key = key_a[i+1];
			assign r_cnt = cnt_a[i+1];
		end

		osm_cell #(
			.COUNT_BITS(COUNT_BITS),
			.SUM_W     (SUM_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.key_b    (key_q),
			.left_lt  (l_lt),
			.left_key (l_key),
			.left_cnt (l_cnt),
			.right_key(r_key),
			.right_cnt(r_cnt),
			.tok_in   (tok_a[i]),
			.res_in   (res_a[i]),
			.key      (key_a[i]),
			.cnt      (cnt_a[i]),
			.lt       (lt_a[i]),
			.eq       (eq_vec[i]),
			.found    (found_vec[i]),
			.tok_out  (tok_a[i+1]),
			.res_out  (res_a[i+1])
		);

		assign occ_vec[i] = (cnt_a[i] != '0);
	end

	// at most one cell flags equal or found, so these are plain and-or selects
	always_comb begin
		hit_cnt   = '0;
		found_key = '0;
		for (int i = 0; i < N; i++) begin
			hit_cnt   = hit_cnt | (eq_vec[i] ? cnt_a[i] : '0);
			found_key = found_key | (found_vec[i] ? key_a[i] : '0);
		end
	end

	assign hit         = |eq_vec;
	assign found_any   = |found_vec;
	assign full        = occ_vec[N-1];
	assign hit_cnt_ext = (COUNT_BITS + CNT_OUT_W)'(hit_cnt);
	assign rank_miss   = (CMPW'(rank_q) >= CMPW'(total_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_CMP;
			end
			S_CMP: begin
				state_d = S_APPLY;
			end
			S_APPLY: begin
				if (op_q == OP_SELECT && !rank_miss) state_d = S_WALK;
				else if (out_free)                    state_d = S_IDLE;
			end
			S_WALK: begin
				if (found_any && out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.op     = CELL_HOLD;
		ctl.cmp_en = (state_q == S_CMP);
		ctl.adv    = !(state_q == S_WALK && found_any && !out_free);
		req_ready  = (state_q == S_IDLE);
		res_wr     = 1'b0;
		total_inc  = 1'b0;
		total_dec  = 1'b0;
		walk_start = 1'b0;
		rsp_d      = '{status: STAT_OK, count: '0, value: '0};
		case (state_q)
			S_APPLY: begin
				case (op_q)
					OP_INSERT: begin
						res_wr = out_free;
						if (hit ? (hit_cnt == '1) : full) begin
							rsp_d.status = STAT_FULL;
						end else begin
							ctl.op    = !out_free ? CELL_HOLD : (hit ? CELL_INC : CELL_INS);
							total_inc = out_free;
						end
					end
					OP_REMOVE: begin
						res_wr = out_free;
						if (!hit) begin
							rsp_d.status = STAT_MISS;
						end else begin
							ctl.op    = !out_free ? CELL_HOLD :
							            ((hit_cnt == COUNT_BITS'(1)) ? CELL_DEL : CELL_DEC);
							total_dec = out_free;
						end
					end
					OP_COUNT: begin
						res_wr = out_free;
						if (hit) rsp_d.count  = hit_cnt_ext[CNT_OUT_W-1:0];
						else     rsp_d.status = STAT_MISS;
					end
					OP_SELECT: begin
						if (rank_miss) begin
							res_wr       = out_free;
							rsp_d.status = STAT_MISS;
						end else begin
							walk_start = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			S_WALK: begin
				res_wr      = found_any && out_free;
				rsp_d.value = found_key;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			state_q <= state_d;
			if (res_wr)         rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
			if (total_inc)      total_q <= total_q + 1'b1;
			else if (total_dec) total_q <= total_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q   <= req.opcode;
			key_q  <= req.key;
			rank_q <= req.rank;
		end
		if (res_wr) rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// occupied slots always form a prefix of the chain
	a_occ_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((occ_vec >> 1) & ~occ_vec) == '0)
		else $error("hole in occupied slots");

	a_total_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q == '0) == !occ_vec[0])
		else $error("item total disagrees with slot occupancy");

	a_found_single: assert property (@(posedge clk) disable iff (!arst_n)
		found_any |-> (state_q == S_WALK) && $onehot(found_vec))
		else $error("rank token found outside walk or in several cells");

	a_tok_end: assert property (@(posedge clk) disable iff (!arst_n)
		!tok_a[N])
		else $error("rank token ran off the end of the chain");

endmodule
`default_nettype wire
